/* rtl/tcce_pkg.sv */
// Shared constants and operation codes for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Cell contents.
  localparam logic [7:0] BLANK_ATTR   = 8'h07;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] LINE_FEED    = 8'd10;
  localparam logic [7:0] CARRIAGE_RET = 8'd13;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_MOVE = 2'd1,
    OP_READ = 2'd2
  } op_t;

endpackage

/* rtl/text_console_cursor_engine_unit.sv */
// Top level of the text console cursor engine: cursor sequencer and screen store.
`timescale 1ns / 1ps

// The engine keeps a screen of COLUMNS by ROWS character cells, each a character
// byte with an attribute byte, in a single RAM with one write and one registered
// read port, together with a text cursor. Each request is one of three
// operations: put a character (line feed, carriage return, lazy wrap at the
// right margin, scrolling at the bottom row), move the cursor, or read one cell.
// Every request produces exactly one result carrying the cursor position and its
// linear offset, plus the cell contents for a read. After reset the engine
// blanks the whole screen, one cell per clock, and accepts nothing until it is
// done. It then takes one request at a time: a move or a carriage return goes
// straight to its result, an ordinary character first writes its cell, and a
// read of a valid cell first fetches the cell through the registered read port.
// A line feed or a wrap on the bottom row scrolls the screen, and that dominates
// the cost: the copy loop moves one cell per clock through the RAM, followed by
// one clock per cell to blank the last row. The output register holds a finished
// result until it is taken, and the next request is accepted meanwhile; its
// result is only held back if the previous one has still not been taken when it
// is ready.

module text_console_cursor_engine_unit
  import tcce_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [6:0]  goto_column,
  input  logic [4:0]  goto_row,
  input  logic [10:0] read_index,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_offset,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attr
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_COPY   = 8'b0000_0100,
    ST_BLANK  = 8'b0000_1000,
    ST_WRITE  = 8'b0001_0000,
    ST_READ   = 8'b0010_0000,
    ST_FETCH  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // Cursor. The column may rest at COLUMNS, which marks a pending wrap.
  logic [COL_W-1:0]  cur_column;
  logic [ROW_W-1:0]  cur_row;

  // Sweep counters. The source pointer runs ahead of the destination during a
  // scroll; the destination pointer also drives the blanking passes.
  logic [CNT_W-1:0]  src;
  logic [ADDR_W-1:0] sweep;
  logic              rd_pend;

  // Held request payload.
  logic              put_pend;
  logic [7:0]        char_hold;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        res_char;
  logic [7:0]        res_attr;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  // Derived cursor values.
  logic [31:0]       cur_lin;
  logic [31:0]       col_wide;
  logic [31:0]       row_wide;
  logic [31:0]       mv_col;
  logic [31:0]       mv_row;
  logic [31:0]       idx_wide;
  logic              at_bottom;
  logic              wrap_due;
  logic              accept;
  logic              load_res;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_res = (state == ST_FINISH) && (!out_valid || out_ready);

  assign col_wide  = 32'(cur_column);
  assign row_wide  = 32'(cur_row);
  assign cur_lin   = row_wide * 32'(COLUMNS) + col_wide;
  assign at_bottom = (cur_row == ROW_W'(ROWS - 1));
  assign wrap_due  = (cur_column == COL_W'(COLUMNS));

  // Move requests saturate to the last column and the last row.
  assign mv_col = (32'(goto_column) > 32'(COLUMNS - 1)) ? 32'(COLUMNS - 1)
                                                         : 32'(goto_column);
  assign mv_row = (32'(goto_row) > 32'(ROWS - 1)) ? 32'(ROWS - 1) : 32'(goto_row);
  assign idx_wide = 32'(read_index);

  // RAM port steering. Reads come from the scroll source pointer while copying
  // and from the held read address otherwise.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = {BLANK_ATTR, SPACE_CHAR};
    ram_raddr = (state == ST_COPY) ? src[ADDR_W-1:0] : rd_addr;
    unique case (state)
      ST_CLEAR, ST_BLANK: begin
        ram_we = 1'b1;
      end
      ST_COPY: begin
        ram_we    = rd_pend;
        ram_wdata = ram_rdata;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_lin[ADDR_W-1:0];
        ram_wdata = {BLANK_ATTR, char_hold};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cur_column <= '0;
      cur_row    <= '0;
      src        <= '0;
      sweep      <= '0;
      rd_pend    <= 1'b0;
      put_pend   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // The output register fills when a result is finished and empties once
      // its result has been taken.
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // Blank every cell once after reset.
        ST_CLEAR: begin
          sweep <= sweep + ADDR_W'(1);
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            res_char <= '0;
            res_attr <= '0;
            case (opcode)
              OP_PUT: begin
                if (char_code == LINE_FEED) begin
                  cur_column <= '0;
                  put_pend   <= 1'b0;
                  if (at_bottom) begin
                    state   <= ST_COPY;
                    src     <= CNT_W'(COLUMNS);
                    sweep   <= '0;
                    rd_pend <= 1'b0;
                  end else begin
                    cur_row <= cur_row + ROW_W'(1);
                    state   <= ST_FINISH;
                  end
                end else if (char_code == CARRIAGE_RET) begin
                  cur_column <= '0;
                  state      <= ST_FINISH;
                end else begin
                  char_hold <= char_code;
                  if (wrap_due) begin
                    cur_column <= '0;
                    if (at_bottom) begin
                      state    <= ST_COPY;
                      put_pend <= 1'b1;
                      src      <= CNT_W'(COLUMNS);
                      sweep    <= '0;
                      rd_pend  <= 1'b0;
                    end else begin
                      cur_row <= cur_row + ROW_W'(1);
                      state   <= ST_WRITE;
                    end
                  end else begin
                    state <= ST_WRITE;
                  end
                end
              end
              OP_MOVE: begin
                cur_column <= mv_col[COL_W-1:0];
                cur_row    <= mv_row[ROW_W-1:0];
                state      <= ST_FINISH;
              end
              OP_READ: begin
                if (idx_wide < 32'(CELLS)) begin
                  rd_addr <= idx_wide[ADDR_W-1:0];
                  state   <= ST_READ;
                end else begin
                  state <= ST_FINISH;
                end
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end

        // Scroll: each cell read one row further down is written back a row
        // higher on the following cycle.
        ST_COPY: begin
          if (src != CNT_W'(CELLS)) begin
            src     <= src + CNT_W'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            sweep <= sweep + ADDR_W'(1);
          end
          if ((src == CNT_W'(CELLS)) && !rd_pend) begin
            state <= ST_BLANK;
          end
        end

        // Blank the last row; the destination pointer already sits at its start.
        ST_BLANK: begin
          sweep <= sweep + ADDR_W'(1);
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= put_pend ? ST_WRITE : ST_FINISH;
          end
        end

        ST_WRITE: begin
          cur_column <= cur_column + COL_W'(1);
          put_pend   <= 1'b0;
          state      <= ST_FINISH;
        end

        ST_READ: begin
          state <= ST_FETCH;
        end

        ST_FETCH: begin
          res_char <= ram_rdata[7:0];
          res_attr <= ram_rdata[15:8];
          state    <= ST_FINISH;
        end

        // Load the output register once the previous result has been taken.
        ST_FINISH: begin
          if (load_res) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_res) begin
      cursor_column <= col_wide[6:0];
      cursor_row    <= row_wide[4:0];
      cursor_offset <= cur_lin[10:0];
      read_char     <= res_char;
      read_attr     <= res_attr;
    end
  end

  tcce_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/tcce_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
